// ----- rtl/core/uvsti_pkg.sv -----
// Package for the UV-sphere triangle index generator.
// Holds shared widths, register indices, phase codes and the triangle record.
// No dependencies.
package uvsti_pkg;

  // Width of the configuration data and of each vertex index.
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int VERT_W    = 16;

  // Default upper bound on the slice counts.
  localparam int MAX_SLICES_DEF = 256;

  // Register indices on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAT_DIVS  = 2'd1;

  // Register values after reset, and their lower bounds.
  localparam int RESET_RING_SIZE = 16;
  localparam int RESET_LAT_DIVS  = 16;
  localparam int MIN_RING_SIZE   = 3;
  localparam int MIN_LAT_DIVS    = 2;

  // Phases of the walk over the mesh.
  localparam logic [1:0] PH_TOP    = 2'd0;
  localparam logic [1:0] PH_PASS1  = 2'd1;
  localparam logic [1:0] PH_PASS2  = 2'd2;
  localparam logic [1:0] PH_BOTTOM = 2'd3;

  // Fixed vertex numbers: the two poles and the start of the first ring.
  localparam logic [VERT_W-1:0] VERT_TOP_POLE    = 16'd0;
  localparam logic [VERT_W-1:0] VERT_BOTTOM_POLE = 16'd1;
  localparam logic [VERT_W-1:0] VERT_FIRST_RING  = 16'd2;

  // One triangle of the index list.
  typedef struct packed {
    logic [VERT_W-1:0] vert_a;
    logic [VERT_W-1:0] vert_b;
    logic [VERT_W-1:0] vert_c;
    logic              last;
  } tri_t;

endpackage

// ----- rtl/core/uvsti_tri_gen.sv -----
// Triangle sequencer: configuration registers, walk state and vertex arithmetic.
// Depends on uvsti_pkg.
module uvsti_tri_gen #(
  parameter int MAX_SLICES = uvsti_pkg::MAX_SLICES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [uvsti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uvsti_pkg::CFG_W-1:0]      cfg_data,
  input  logic                             step,
  input  logic                             restart,
  output uvsti_pkg::tri_t                  tri_out
);

  // CNT_W holds a slice count up to MAX_SLICES; COL_W holds a column or band index.
  localparam int CNT_W = $clog2(MAX_SLICES + 1);
  localparam int COL_W = $clog2(MAX_SLICES);
  localparam int VW    = uvsti_pkg::VERT_W;

  localparam int RST_U = (uvsti_pkg::RESET_RING_SIZE > MAX_SLICES) ?
                         MAX_SLICES : uvsti_pkg::RESET_RING_SIZE;
  localparam int RST_V = (uvsti_pkg::RESET_LAT_DIVS > MAX_SLICES) ?
                         MAX_SLICES : uvsti_pkg::RESET_LAT_DIVS;

  // Saturate a written count into lo..MAX_SLICES.
  function automatic logic [CNT_W-1:0] clamp_cnt(input logic [uvsti_pkg::CFG_W-1:0] x,
                                                 input int lo);
    int xi;
    xi = int'(x);
    if (xi < lo) begin
      return CNT_W'(lo);
    end else if (xi > MAX_SLICES) begin
      return CNT_W'(MAX_SLICES);
    end else begin
      return CNT_W'(xi);
    end
  endfunction

  logic [CNT_W-1:0] ring_size;
  logic [CNT_W-1:0] lat_divs;

  logic [1:0]       phase;
  logic [COL_W-1:0] column;
  logic [COL_W-1:0] band;
  logic [VW-1:0]    ring_base;

  logic [1:0]       phase_next;
  logic [COL_W-1:0] column_next;
  logic [COL_W-1:0] band_next;
  logic [VW-1:0]    ring_base_next;

  // State as seen by this step, after an optional restart.
  logic [1:0]       ph_cur;
  logic [COL_W-1:0] col_cur;
  logic [COL_W-1:0] band_cur;
  logic [VW-1:0]    base_cur;

  logic [CNT_W-1:0] col_inc;
  logic [CNT_W-1:0] band_inc;
  logic             end_of_ring;
  logic [COL_W-1:0] col_nxt;
  logic [VW-1:0]    u16;
  logic [VW-1:0]    col16;
  logic [VW-1:0]    nxt16;
  logic [VW-1:0]    next_ring;
  logic             cfg_hit;

  assign cfg_hit = cfg_we && (cfg_index == uvsti_pkg::REG_RING_SIZE ||
                              cfg_index == uvsti_pkg::REG_LAT_DIVS);

  always_comb begin
    if (restart) begin
      ph_cur   = uvsti_pkg::PH_TOP;
      col_cur  = '0;
      band_cur = '0;
      base_cur = uvsti_pkg::VERT_FIRST_RING;
    end else begin
      ph_cur   = phase;
      col_cur  = column;
      band_cur = band;
      base_cur = ring_base;
    end
  end

  assign col_inc     = CNT_W'(col_cur) + CNT_W'(1);
  assign band_inc    = CNT_W'(band_cur) + CNT_W'(1);
  assign end_of_ring = (col_inc >= ring_size);
  assign col_nxt     = end_of_ring ? '0 : col_inc[COL_W-1:0];
  assign u16         = VW'(ring_size);
  assign col16       = VW'(col_cur);
  assign nxt16       = VW'(col_nxt);
  assign next_ring   = base_cur + u16;

  always_comb begin
    tri_out.last   = 1'b0;
    phase_next     = ph_cur;
    column_next    = col_nxt;
    band_next      = band_cur;
    ring_base_next = base_cur;
    unique case (ph_cur)
      uvsti_pkg::PH_TOP: begin
        tri_out.vert_a = uvsti_pkg::VERT_TOP_POLE;
        tri_out.vert_b = uvsti_pkg::VERT_FIRST_RING + col16;
        tri_out.vert_c = uvsti_pkg::VERT_FIRST_RING + nxt16;
        if (end_of_ring) begin
          band_next      = '0;
          ring_base_next = uvsti_pkg::VERT_FIRST_RING;
          phase_next     = (lat_divs > CNT_W'(uvsti_pkg::MIN_LAT_DIVS)) ?
                           uvsti_pkg::PH_PASS1 : uvsti_pkg::PH_BOTTOM;
        end
      end
      uvsti_pkg::PH_PASS1: begin
        tri_out.vert_a = base_cur + nxt16;
        tri_out.vert_b = base_cur + col16;
        tri_out.vert_c = next_ring + col16;
        if (end_of_ring) begin
          phase_next = uvsti_pkg::PH_PASS2;
        end
      end
      uvsti_pkg::PH_PASS2: begin
        tri_out.vert_a = next_ring + col16;
        tri_out.vert_b = next_ring + nxt16;
        tri_out.vert_c = base_cur + nxt16;
        if (end_of_ring) begin
          ring_base_next = next_ring;
          band_next      = band_inc[COL_W-1:0];
          phase_next     = (band_inc >= lat_divs - CNT_W'(uvsti_pkg::MIN_LAT_DIVS)) ?
                           uvsti_pkg::PH_BOTTOM : uvsti_pkg::PH_PASS1;
        end
      end
      default: begin
        tri_out.vert_a = uvsti_pkg::VERT_BOTTOM_POLE;
        tri_out.vert_b = base_cur + nxt16;
        tri_out.vert_c = base_cur + col16;
        if (end_of_ring) begin
          tri_out.last   = 1'b1;
          phase_next     = uvsti_pkg::PH_TOP;
          band_next      = '0;
          ring_base_next = uvsti_pkg::VERT_FIRST_RING;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size <= CNT_W'(RST_U);
      lat_divs  <= CNT_W'(RST_V);
      phase     <= uvsti_pkg::PH_TOP;
      column    <= '0;
      band      <= '0;
      ring_base <= uvsti_pkg::VERT_FIRST_RING;
    end else if (cfg_hit) begin
      if (cfg_index == uvsti_pkg::REG_RING_SIZE) begin
        ring_size <= clamp_cnt(cfg_data, uvsti_pkg::MIN_RING_SIZE);
      end else begin
        lat_divs <= clamp_cnt(cfg_data, uvsti_pkg::MIN_LAT_DIVS);
      end
      phase     <= uvsti_pkg::PH_TOP;
      column    <= '0;
      band      <= '0;
      ring_base <= uvsti_pkg::VERT_FIRST_RING;
    end else if (step) begin
      phase     <= phase_next;
      column    <= column_next;
      band      <= band_next;
      ring_base <= ring_base_next;
    end
  end

  // The column never reaches the ring length.
  a_col_in_ring: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(column) < ring_size)
    else $error("column outside ring");

  // Band phases only exist when there is at least one inner band.
  a_band_needs_rings: assert property (@(posedge clk) disable iff (rst)
    (phase == uvsti_pkg::PH_PASS1 || phase == uvsti_pkg::PH_PASS2) |->
      lat_divs > CNT_W'(uvsti_pkg::MIN_LAT_DIVS))
    else $error("band phase with no inner band");

  // A step that closes the mesh leaves the walk at the start of the top cap.
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (step && !cfg_hit && tri_out.last) |=>
      (phase == uvsti_pkg::PH_TOP && column == '0))
    else $error("walk not restarted after closing triangle");

endmodule

// ----- rtl/core/uvsti_out_buf.sv -----
// Two-entry result buffer (output register plus skid stage) for triangle records.
// Depends on uvsti_pkg.
module uvsti_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_stall,
  input  uvsti_pkg::tri_t push_data,
  output logic            pop_valid,
  input  logic            pop_stall,
  output uvsti_pkg::tri_t pop_data
);

  logic            out_valid;
  uvsti_pkg::tri_t out_data;
  logic            skid_valid;
  uvsti_pkg::tri_t skid_data;
  logic            push;
  logic            pop;

  assign push_stall = skid_valid;
  assign push       = push_valid && !skid_valid;
  assign pop        = out_valid && !pop_stall;
  assign pop_valid  = out_valid;
  assign pop_data   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_data <= skid_data;
    end else if (push && (pop || !out_valid)) begin
      out_data <= push_data;
    end
    if (push && out_valid && !pop) begin
      skid_data <= push_data;
    end
  end

  // The skid stage only fills behind an occupied output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds data with empty output register");

  // A request arriving while the output is held lands in the skid stage.
  a_skid_catches: assert property (@(posedge clk) disable iff (rst)
    (push && out_valid && pop_stall) |=> skid_valid)
    else $error("request lost while output stalled");

endmodule

// ----- rtl/core/uv_sphere_triangle_index_gen.sv -----
// Top level of the UV-sphere triangle index generator.
// Depends on uvsti_pkg, uvsti_tri_gen and uvsti_out_buf.
//
//   channel  | signals                                | direction
//   ---------+----------------------------------------+-----------
//   request  | req_valid, req_stall, restart          | in / stall out
//   triangle | tri_valid, tri_stall, vert_a/b/c, last | out / stall in
//   config   | cfg_we, cfg_index, cfg_data            | in, write only
//
// Each accepted request yields exactly one triangle. With the output free it
// is presented from the output register in the cycle after acceptance, and a
// request can be accepted in every cycle.
// The rate is set by the single pass from walk state to output register:
// one counter step and a few 16-bit adds.
// Reset (rst, synchronous) loads 16 slices each way and starts at the top cap.
// A held triangle does not stop intake: one more request is caught in the
// skid stage, and req_stall rises only once that stage is full.
//
// Vertex 0 is the top pole, vertex 1 the bottom pole, and ring r starts at
// 2 + (r-1)*ring_size. The walk emits the top-cap fan, then two passes per
// inner band, then the bottom-cap fan; the closing triangle carries last.
// Writing either register saturates it into range and restarts the walk.
module uv_sphere_triangle_index_gen #(
  parameter int MAX_SLICES = uvsti_pkg::MAX_SLICES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [uvsti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [uvsti_pkg::CFG_W-1:0]      cfg_data,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic                             restart,
  output logic                             tri_valid,
  input  logic                             tri_stall,
  output logic [uvsti_pkg::VERT_W-1:0]     vert_a,
  output logic [uvsti_pkg::VERT_W-1:0]     vert_b,
  output logic [uvsti_pkg::VERT_W-1:0]     vert_c,
  output logic                             last
);

  uvsti_pkg::tri_t tri_new;
  uvsti_pkg::tri_t tri_held;
  logic            req_take;

  // The walk only moves when a request is really taken.
  assign req_take = req_valid && !req_stall;

  uvsti_tri_gen #(
    .MAX_SLICES (MAX_SLICES)
  ) u_tri_gen (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (req_take),
    .restart   (restart),
    .tri_out   (tri_new)
  );

  uvsti_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (req_valid),
    .push_stall (req_stall),
    .push_data  (tri_new),
    .pop_valid  (tri_valid),
    .pop_stall  (tri_stall),
    .pop_data   (tri_held)
  );

  assign vert_a = tri_held.vert_a;
  assign vert_b = tri_held.vert_b;
  assign vert_c = tri_held.vert_c;
  assign last   = tri_held.last;

  // A taken request leaves a triangle presented in the next cycle.
  a_req_gives_tri: assert property (@(posedge clk) disable iff (rst)
    req_take |=> tri_valid)
    else $error("request taken but no triangle presented");

endmodule
